@@ rtl/core/dpc_pkg.sv @@
// types, codes and constants shared by the pxe request classifier
`default_nettype none

package dpc_pkg;

    // fixed header layout
    localparam logic [7:0]  HEADER_BYTES = 8'd240;
    localparam logic [7:0]  XID_FIRST    = 8'd4;
    localparam logic [7:0]  XID_LAST     = 8'd7;
    localparam logic [7:0]  MAC_FIRST    = 8'd28;
    localparam logic [7:0]  MAC_LAST     = 8'd33;
    localparam logic [31:0] COOKIE_VALUE = 32'h6382_5363;

    // option ids
    localparam logic [7:0] OPT_PAD      = 8'd0;
    localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
    localparam logic [7:0] OPT_VENDOR   = 8'd60;
    localparam logic [7:0] OPT_END      = 8'd255;

    // dhcp message types
    localparam logic [7:0] TYPE_DISCOVER = 8'd1;
    localparam logic [7:0] TYPE_REQUEST  = 8'd3;

    // vendor class prefix length that counts as pxe
    localparam logic [3:0] VENDOR_TAG_LEN = 4'd9;

    // packet kind codes
    localparam logic [2:0] KIND_INVALID  = 3'd0;
    localparam logic [2:0] KIND_NOT_PXE  = 3'd1;
    localparam logic [2:0] KIND_DISCOVER = 3'd2;
    localparam logic [2:0] KIND_REQUEST  = 3'd3;
    localparam logic [2:0] KIND_OTHER    = 3'd4;

    // option parse phase
    typedef enum logic [1:0] {
        PH_ID   = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2,
        PH_DONE = 2'd3
    } t_phase;

    // request and result payloads
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_req;

    typedef struct packed {
        logic [2:0]  packet_kind;
        logic [7:0]  message_type;
        logic [31:0] transaction_id;
        logic [47:0] client_mac;
    } t_res;

    // option state as seen after the current byte
    typedef struct packed {
        logic       pxe_seen;
        logic [7:0] type_seen;
    } t_opt_flags;

    // vendor class prefix "PXEClient", zero beyond it
    function automatic logic [7:0] pxe_tag_byte(input logic [3:0] idx);
        logic [7:0] v;
        unique case (idx)
            4'd0:    v = 8'h50;
            4'd1:    v = 8'h58;
            4'd2:    v = 8'h45;
            4'd3:    v = 8'h43;
            4'd4:    v = 8'h6c;
            4'd5:    v = 8'h69;
            4'd6:    v = 8'h65;
            4'd7:    v = 8'h6e;
            4'd8:    v = 8'h74;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/dpc_stream_if.sv @@
// valid/ready stream interface with a typed payload
`default_nettype none

interface dpc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/core/dpc_opt_parser.sv @@
// option record parser: tracks vendor class and message type options
`default_nettype none

module dpc_opt_parser
    import dpc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic       i_clear,
    input  wire logic [7:0] i_data,
    output t_opt_flags      o_flags
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_cur, n_cur;
    logic [7:0] r_left, n_left;
    logic [3:0] r_idx, n_idx;
    logic       r_match, n_match;
    logic [8:0] r_ptype, n_ptype;
    logic       r_pxe, n_pxe;
    logic [7:0] r_type, n_type;
    logic       w_finish;

    // a record closes on a zero length byte or on its last value byte
    always_comb begin
        w_finish = 1'b0;
        if (i_step) begin
            if (r_phase == PH_LEN) begin
                w_finish = (i_data == 8'd0);
            end else if (r_phase == PH_DATA) begin
                w_finish = (r_left == 8'd1);
            end
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_step) begin
            unique case (r_phase)
                PH_ID: begin
                    if (i_data == OPT_END) begin
                        n_phase = PH_DONE;
                    end else if (i_data != OPT_PAD) begin
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN:  n_phase = w_finish ? PH_ID : PH_DATA;
                PH_DATA: n_phase = w_finish ? PH_ID : PH_DATA;
                default: n_phase = PH_DONE;
            endcase
        end
    end

    // record fields and option results
    always_comb begin
        n_cur   = r_cur;
        n_left  = r_left;
        n_idx   = r_idx;
        n_match = r_match;
        n_ptype = r_ptype;
        n_pxe   = r_pxe;
        n_type  = r_type;
        if (i_step) begin
            unique case (r_phase)
                PH_ID: begin
                    if (i_data != OPT_END && i_data != OPT_PAD) begin
                        n_cur = i_data;
                    end
                end
                PH_LEN: begin
                    n_left  = i_data;
                    n_idx   = 4'd0;
                    n_match = 1'b1;
                    n_ptype = 9'd0;
                end
                PH_DATA: begin
                    if (r_idx < VENDOR_TAG_LEN && i_data != pxe_tag_byte(r_idx)) begin
                        n_match = 1'b0;
                    end
                    if (r_idx == 4'd0) begin
                        n_ptype = {1'b1, i_data};
                    end
                    if (r_idx != 4'hf) begin
                        n_idx = r_idx + 4'd1;
                    end
                    n_left = r_left - 8'd1;
                end
                default: begin
                end
            endcase
            // close the record with the values just formed
            if (w_finish) begin
                if (r_cur == OPT_VENDOR) begin
                    n_pxe = n_match && (n_idx >= VENDOR_TAG_LEN);
                end else if (r_cur == OPT_MSG_TYPE) begin
                    n_type = n_ptype[8] ? n_ptype[7:0] : 8'd0;
                end
            end
        end
    end

    assign o_flags.pxe_seen  = n_pxe;
    assign o_flags.type_seen = n_type;

    // state registers, cleared at the end of each packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_phase <= PH_ID;
            r_cur   <= 8'd0;
            r_left  <= 8'd0;
            r_idx   <= 4'd0;
            r_match <= 1'b0;
            r_ptype <= 9'd0;
            r_pxe   <= 1'b0;
            r_type  <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_cur   <= n_cur;
            r_left  <= n_left;
            r_idx   <= n_idx;
            r_match <= n_match;
            r_ptype <= n_ptype;
            r_pxe   <= n_pxe;
            r_type  <= n_type;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/dhcp_pxe_request_classifier.sv @@
// dhcp pxe request classifier top level
//
//  channel  | dir | payload                                          | role
//  ---------+-----+--------------------------------------------------+---------------------------
//  i_req    | in  | data_byte[7:0], last_byte                        | datagram bytes, one each
//  o_res    | out | packet_kind[2:0], message_type[7:0],             | one result per datagram
//           |     | transaction_id[31:0], client_mac[47:0]           |
//
//  one request is taken per cycle while ready; header/option state update on the accepting edge
//  a request with last_byte set loads the result register on the same edge and clears all state
//  i_req.ready is low only while a result is held and o_res.ready is low
//  synchronous active-low reset clears parse state and the result valid flag
`default_nettype none

module dhcp_pxe_request_classifier
    import dpc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dpc_stream_if.sink   i_req,
    dpc_stream_if.source o_res
);

    logic [7:0]  r_pos, n_pos;
    logic [31:0] r_cookie, n_cookie;
    logic [31:0] r_xid, n_xid;
    logic [47:0] r_mac, n_mac;
    logic        r_res_valid;
    t_res        r_res, n_res;
    logic        w_in_acc;
    logic        w_in_hdr;
    logic        w_last;
    logic [7:0]  w_byte;
    t_opt_flags  w_flags;

    assign w_byte      = i_req.payload.data_byte;
    assign w_last      = i_req.payload.last_byte;
    assign i_req.ready = !r_res_valid || o_res.ready;
    assign w_in_acc    = i_req.valid && i_req.ready;
    assign w_in_hdr    = (r_pos < HEADER_BYTES);

    // header capture
    always_comb begin
        n_pos    = r_pos;
        n_cookie = r_cookie;
        n_xid    = r_xid;
        n_mac    = r_mac;
        if (w_in_acc && w_in_hdr) begin
            if (r_pos >= XID_FIRST && r_pos <= XID_LAST) begin
                n_xid = {r_xid[23:0], w_byte};
            end
            if (r_pos >= MAC_FIRST && r_pos <= MAC_LAST) begin
                n_mac = {r_mac[39:0], w_byte};
            end
            n_cookie = {r_cookie[23:0], w_byte};
            n_pos    = r_pos + 8'd1;
        end
    end

    // option parser
    dpc_opt_parser u_opt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_in_acc && !w_in_hdr),
        .i_clear (w_in_acc && w_last),
        .i_data  (w_byte),
        .o_flags (w_flags)
    );

    // classification of the finished packet
    always_comb begin
        n_res = '0;
        if (n_pos >= HEADER_BYTES && n_cookie == COOKIE_VALUE) begin
            n_res.message_type   = w_flags.type_seen;
            n_res.transaction_id = n_xid;
            n_res.client_mac     = n_mac;
            if (!w_flags.pxe_seen) begin
                n_res.packet_kind = KIND_NOT_PXE;
            end else if (w_flags.type_seen == TYPE_DISCOVER) begin
                n_res.packet_kind = KIND_DISCOVER;
            end else if (w_flags.type_seen == TYPE_REQUEST) begin
                n_res.packet_kind = KIND_REQUEST;
            end else begin
                n_res.packet_kind = KIND_OTHER;
            end
        end
    end

    // header state, cleared after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_in_acc && w_last)) begin
            r_pos    <= 8'd0;
            r_cookie <= 32'd0;
            r_xid    <= 32'd0;
            r_mac    <= 48'd0;
        end else begin
            r_pos    <= n_pos;
            r_cookie <= n_cookie;
            r_xid    <= n_xid;
            r_mac    <= n_mac;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_in_acc && w_last) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_last) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid   = r_res_valid;
    assign o_res.payload = r_res;

`ifndef SYNTHESIS
    // an invalid packet carries all-zero fields
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.packet_kind == KIND_INVALID) |->
        (r_res.message_type == 8'd0 && r_res.transaction_id == 32'd0 &&
         r_res.client_mac == 48'd0))
        else $error("invalid result with nonzero fields");

    // a final byte always produces a result on the next cycle
    a_last_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_last) |=> r_res_valid)
        else $error("final byte did not load a result");

    // header position restarts after the final byte
    a_pos_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_last) |=> (r_pos == 8'd0))
        else $error("header position not cleared after packet end");

    // pxe discover and request kinds agree with the message type
    a_kind_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && (r_res.packet_kind == KIND_DISCOVER ||
                         r_res.packet_kind == KIND_REQUEST)) |->
        (r_res.message_type == TYPE_DISCOVER || r_res.message_type == TYPE_REQUEST))
        else $error("packet kind disagrees with message type");
`endif

endmodule

`default_nettype wire
